// ===== sv/gvss_pkg.sv =====
// Shared types and constants for the greedy vertical seam search block.
// Used by every module of the block but gvss_ram, and by its port checker; depends on nothing.
package gvss_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int FIELD_W   = 9;
  localparam int ENERGY_W  = 16;
  localparam int TOTAL_W   = 32;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Result kinds.
  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_SEAM  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;

  localparam logic [CFG_W-1:0] DIM_RESET = 10'd512;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [FIELD_W-1:0]  row;
    logic [FIELD_W-1:0]  col;
    logic [ENERGY_W-1:0] energy;
  } req_t;

  typedef struct packed {
    logic                result_kind;
    logic [TOTAL_W-1:0]  total_energy;
    logic [FIELD_W-1:0]  seam_col;
    logic [FIELD_W-1:0]  row_index;
  } rsp_t;

  // Operations of the shared compare and add unit.
  typedef enum logic [1:0] {
    ALU_CAND,
    ALU_ACC,
    ALU_END
  } alu_op_t;

  typedef struct packed {
    logic               lt;
    logic [TOTAL_W-1:0] sum;
  } alu_res_t;

endpackage

// ===== sv/gvss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module gvss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/gvss_alu.sv =====
// Shared compare and add unit of the seam search: one 32-bit adder and one comparator.
// Depends on gvss_pkg for the operation code and result struct.
module gvss_alu (
  input  gvss_pkg::alu_op_t                op,
  input  logic [gvss_pkg::ENERGY_W-1:0]    sample,
  input  logic [gvss_pkg::ENERGY_W-1:0]    cost,
  input  logic [gvss_pkg::TOTAL_W-1:0]     run,
  input  logic [gvss_pkg::TOTAL_W-1:0]     lowest,
  output gvss_pkg::alu_res_t               res
);
  import gvss_pkg::*;

  logic [TOTAL_W-1:0] opa;
  logic [TOTAL_W-1:0] opb;
  logic [TOTAL_W-1:0] sum;

  always_comb begin
    sum = run + TOTAL_W'(cost);
    unique case (op)
      ALU_CAND: begin
        opa = TOTAL_W'(sample);
        opb = TOTAL_W'(cost);
      end
      ALU_ACC: begin
        // The path is abandoned once its cost exceeds the best total.
        opa = lowest;
        opb = sum;
      end
      ALU_END: begin
        opa = run;
        opb = lowest;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    res.lt  = opa < opb;
    res.sum = sum;
  end

endmodule

// ===== sv/greedy_vertical_seam_search.sv =====
// Greedy vertical seam search: top level with the sequencer, the stores and the ports.
// Depends on gvss_pkg, gvss_ram and gvss_alu.
//
// The block holds an energy map of MAX_ROWS x MAX_COLS unsigned Q2.14 samples and answers
// three kinds of request on the req channel. A write stores one sample at (row, col);
// writes outside the map are dropped, and no result follows. A search walks one greedy
// path from every column of row 0 of the area set by rows_used and cols_used, keeps the
// first path with the strictly lowest total and returns that total (all ones only if no
// path finished below it). A read returns the kept seam's column at one row. The search
// is done by one shared compare and add unit under a sequencer, and the energy map has a
// single read port, so each row of a path is walked in steps: address the centre sample,
// take the centre sample and then the left and right ones, where they exist, as they come
// back, and accumulate. Each path is judged at its end, and one that becomes the new best
// is copied into the seam store at one row per cycle. req_ready stays low throughout a
// search. Results go through an output register, so a new request is taken while the
// last result still waits to be transferred; a result is only loaded when that register
// is free. The configuration port is always ready and is to be written only while the
// block is idle.
module greedy_vertical_seam_search #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  gvss_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output gvss_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gvss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gvss_pkg::CFG_W-1:0]     cfg_data
);
  import gvss_pkg::*;

  localparam int RW      = $clog2(MAX_ROWS);
  localparam int CW      = $clog2(MAX_COLS);
  localparam int MAXW    = (RW > CW) ? ((RW > CFG_W) ? RW : CFG_W)
                                     : ((CW > CFG_W) ? CW : CFG_W);
  localparam int CMPW    = MAXW + 1;
  // The map is addressed as {row, col}, so each row occupies a power-of-two span.
  localparam int E_DEPTH = MAX_ROWS * (2 ** CW);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SEAM     = 12'b0000_0000_0010,
    S_START    = 12'b0000_0000_0100,
    S_RD_C     = 12'b0000_0000_1000,
    S_GET_C    = 12'b0000_0001_0000,
    S_GET_L    = 12'b0000_0010_0000,
    S_GET_R    = 12'b0000_0100_0000,
    S_ACC      = 12'b0000_1000_0000,
    S_END      = 12'b0001_0000_0000,
    S_COPY     = 12'b0010_0000_0000,
    S_COPY_END = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [CFG_W-1:0] rows_used;
  logic [CFG_W-1:0] cols_used;

  // Search bounds and walking registers.
  logic [RW-1:0]       nr_last;
  logic [CW-1:0]       nc_last;
  logic [CW-1:0]       start_col;
  logic [CW-1:0]       at;
  logic [CW-1:0]       pick;
  logic [ENERGY_W-1:0] cost;
  logic [TOTAL_W-1:0]  run;
  logic [TOTAL_W-1:0]  lowest;
  logic [RW-1:0]       r;
  logic [RW-1:0]       k;
  logic [RW-1:0]       kd;
  logic                cp_v;

  // Seam read bookkeeping.
  logic [FIELD_W-1:0] rd_row;
  logic               rd_in_range;

  // Output register.
  rsp_t rsp_next;
  logic rsp_load;
  logic rsp_free;

  // Derived bounds.
  logic [CMPW-1:0] rows_ext;
  logic [CMPW-1:0] cols_ext;
  logic [CMPW-1:0] rows_eff;
  logic [CMPW-1:0] cols_eff;
  logic [RW-1:0]   rows_last;
  logic [CW-1:0]   cols_last;

  logic [CW-1:0] at_dec;
  logic [CW-1:0] at_inc;
  logic          req_row_ok;
  logic          req_col_ok;
  logic          req_take;

  // Memory ports.
  logic                e_we;
  logic [RW+CW-1:0]    e_waddr;
  logic                e_re;
  logic [RW+CW-1:0]    e_raddr;
  logic [ENERGY_W-1:0] e_rdata;

  logic          p_we;
  logic [RW-1:0] p_waddr;
  logic [CW-1:0] p_wdata;
  logic          p_re;
  logic [CW-1:0] p_rdata;

  logic          b_we;
  logic          b_re;
  logic [RW-1:0] b_raddr;
  logic [CW-1:0] b_rdata;

  alu_op_t  alu_op;
  alu_res_t alu_res;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign req_take  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign at_dec = at - 1'b1;
  assign at_inc = at + 1'b1;

  assign req_row_ok = 32'(req.row) < 32'(MAX_ROWS);
  assign req_col_ok = 32'(req.col) < 32'(MAX_COLS);

  // A dimension of zero acts as one, and one beyond the map acts as the map's size.
  always_comb begin
    rows_ext = CMPW'(rows_used);
    cols_ext = CMPW'(cols_used);
    if (rows_ext == '0) begin
      rows_eff = CMPW'(1);
    end else if (rows_ext > CMPW'(MAX_ROWS)) begin
      rows_eff = CMPW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    if (cols_ext == '0) begin
      cols_eff = CMPW'(1);
    end else if (cols_ext > CMPW'(MAX_COLS)) begin
      cols_eff = CMPW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    rows_last = RW'(rows_eff - 1'b1);
    cols_last = CW'(cols_eff - 1'b1);
  end

  // Samples are written straight from an accepted write transfer.
  assign e_we    = req_take && (req.req_type == REQ_WRITE) && req_row_ok && req_col_ok;
  assign e_waddr = {RW'(req.row), CW'(req.col)};

  // Sequencer: next state, memory controls and the shared unit's operation.
  always_comb begin
    state_next = state;
    e_re       = 1'b0;
    e_raddr    = {r, at};
    p_we       = 1'b0;
    p_waddr    = r;
    p_wdata    = pick;
    p_re       = 1'b0;
    b_we       = 1'b0;
    b_re       = 1'b0;
    b_raddr    = RW'(req.row);
    alu_op     = ALU_CAND;
    rsp_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_SEARCH) begin
            state_next = S_START;
          end else if (req.req_type == REQ_READ) begin
            b_re       = 1'b1;
            state_next = S_SEAM;
          end
        end
      end
      S_SEAM: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_START: begin
        // Row 0 of the path is its start column.
        p_we       = 1'b1;
        p_waddr    = '0;
        p_wdata    = start_col;
        state_next = (nr_last == '0) ? S_END : S_RD_C;
      end
      S_RD_C: begin
        e_re       = 1'b1;
        e_raddr    = {r, at};
        state_next = S_GET_C;
      end
      S_GET_C: begin
        if (at != '0) begin
          e_re       = 1'b1;
          e_raddr    = {r, at_dec};
          state_next = S_GET_L;
        end else if (at != nc_last) begin
          e_re       = 1'b1;
          e_raddr    = {r, at_inc};
          state_next = S_GET_R;
        end else begin
          state_next = S_ACC;
        end
      end
      S_GET_L: begin
        alu_op = ALU_CAND;
        if (at != nc_last) begin
          e_re       = 1'b1;
          e_raddr    = {r, at_inc};
          state_next = S_GET_R;
        end else begin
          state_next = S_ACC;
        end
      end
      S_GET_R: begin
        alu_op     = ALU_CAND;
        state_next = S_ACC;
      end
      S_ACC: begin
        alu_op  = ALU_ACC;
        p_we    = 1'b1;
        p_waddr = r;
        p_wdata = pick;
        if (alu_res.lt || (r == nr_last)) begin
          state_next = S_END;
        end else begin
          state_next = S_RD_C;
        end
      end
      S_END: begin
        alu_op = ALU_END;
        if (alu_res.lt) begin
          state_next = S_COPY;
        end else if (start_col == nc_last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_START;
        end
      end
      S_COPY: begin
        // Read row k of the path while the row read before it is stored.
        p_re = 1'b1;
        b_we = cp_v;
        if (k == nr_last) begin
          state_next = S_COPY_END;
        end
      end
      S_COPY_END: begin
        b_we       = 1'b1;
        state_next = (start_col == nc_last) ? S_RESP : S_START;
      end
      S_RESP: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result assembly for the output register.
  always_comb begin
    if (state == S_SEAM) begin
      rsp_next.result_kind  = KIND_SEAM;
      rsp_next.total_energy = '0;
      rsp_next.seam_col     = rd_in_range ? FIELD_W'(b_rdata) : '0;
      rsp_next.row_index    = rd_row;
    end else begin
      rsp_next.result_kind  = KIND_TOTAL;
      rsp_next.total_energy = lowest;
      rsp_next.seam_col     = '0;
      rsp_next.row_index    = '0;
    end
  end

  // Control state, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rows_used <= DIM_RESET;
      cols_used <= DIM_RESET;
      rsp_valid <= 1'b0;
      cp_v      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_ROWS_USED) begin
          rows_used <= cfg_data;
        end else if (cfg_index == CFG_COLS_USED) begin
          cols_used <= cfg_data;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_COPY) begin
        cp_v <= 1'b1;
      end else begin
        cp_v <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest <= '1;
      run    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.req_type == REQ_SEARCH) begin
              nr_last   <= rows_last;
              nc_last   <= cols_last;
              start_col <= '0;
              lowest    <= '1;
            end else if (req.req_type == REQ_READ) begin
              rd_row      <= req.row;
              rd_in_range <= req_row_ok;
            end
          end
        end
        S_START: begin
          at  <= start_col;
          run <= '0;
          r   <= RW'(1);
        end
        S_GET_C: begin
          cost <= e_rdata;
          pick <= at;
        end
        S_GET_L: begin
          if (alu_res.lt) begin
            cost <= e_rdata;
            pick <= at_dec;
          end
        end
        S_GET_R: begin
          if (alu_res.lt) begin
            cost <= e_rdata;
            pick <= at_inc;
          end
        end
        S_ACC: begin
          run <= alu_res.sum;
          at  <= pick;
          r   <= r + 1'b1;
        end
        S_END: begin
          if (alu_res.lt) begin
            lowest <= run;
            k      <= '0;
          end else begin
            start_col <= start_col + 1'b1;
          end
        end
        S_COPY: begin
          kd <= k;
          k  <= k + 1'b1;
        end
        S_COPY_END: begin
          start_col <= start_col + 1'b1;
        end
        S_SEAM, S_RD_C, S_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

  gvss_alu u_alu (
    .op     (alu_op),
    .sample (e_rdata),
    .cost   (cost),
    .run    (run),
    .lowest (lowest),
    .res    (alu_res)
  );

  gvss_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (E_DEPTH)
  ) u_energy_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (req.energy),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // Path being walked.
  gvss_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ROWS)
  ) u_path_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (k),
    .rdata (p_rdata)
  );

  // Kept seam.
  gvss_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ROWS)
  ) u_best_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (kd),
    .wdata (p_rdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

endmodule

// ===== sv/gvss_check.sv =====
// Port checker for the greedy vertical seam search, bound to the top level.
// Depends on gvss_pkg and greedy_vertical_seam_search.
module gvss_check (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input gvss_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input gvss_pkg::rsp_t rsp
);
  import gvss_pkg::*;

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  // A search transfer takes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.req_type == REQ_SEARCH) |=> !req_ready)
    else $error("block still ready after a search transfer");

  // A seam read transfer takes the block busy while the entry is fetched.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.req_type == REQ_READ) |=> !req_ready)
    else $error("block still ready after a read transfer");

  // Sample writes and unused codes never stall the request side.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.req_type != REQ_SEARCH) && (req.req_type != REQ_READ)
    |=> req_ready)
    else $error("block stalled after a write transfer");

endmodule

bind greedy_vertical_seam_search gvss_check u_check (.*);

// ===== test/greedy_vertical_seam_search_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for greedy_vertical_seam_search: directed table, then random phases.
// Depends on gvss_pkg and the greedy_vertical_seam_search RTL only.
module greedy_vertical_seam_search_test;
  import gvss_pkg::*;

  localparam int MAP_ROWS = 512;
  localparam int MAP_COLS = 512;
  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  // A write may still be in flight once the last result is in; this covers it.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  // The slowest search in the phases (512 rows, one column) makes no transfer anywhere
  // while it runs; the limit is set to cover it.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PRESSURE_READS = 24;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       value;
    req_t                   item;
    bit                     fixed;
    rsp_t                   want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_t                 rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  greedy_vertical_seam_search #(
    .MAX_ROWS(MAP_ROWS),
    .MAX_COLS(MAP_COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow state of the block, updated at every accepted transfer.
  logic [ENERGY_W-1:0] energy_map [0:MAP_ROWS*MAP_COLS-1];
  bit                  energy_known [0:MAP_ROWS*MAP_COLS-1];
  logic [FIELD_W-1:0]  trail [0:MAP_ROWS-1];
  logic [FIELD_W-1:0]  kept_seam [0:MAP_ROWS-1];
  int unsigned         seam_rows_kept;
  logic [TOTAL_W-1:0]  lowest_total;
  logic [TOTAL_W-1:0]  running_total;
  logic [CFG_W-1:0]    rows_used_reg;
  logic [CFG_W-1:0]    cols_used_reg;

  rsp_t        pending_answers [$];
  plan_row_t   directed_plan [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          calm;
  int unsigned hold_off_asked;

  always #HALF_PERIOD clk = ~clk;

  // Zero and out-of-range settings are pulled back into 1 .. limit.
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // One greedy path per start column; the first strictly lowest total is kept.
  task automatic walk_greedy_seams();
    int unsigned nr;
    int unsigned nc;
    int unsigned start;
    int unsigned r;
    int unsigned here;
    int unsigned pick;
    logic [TOTAL_W-1:0] cost;
    nr = eff_dim(rows_used_reg, MAP_ROWS);
    nc = eff_dim(cols_used_reg, MAP_COLS);
    lowest_total = '1;
    for (start = 0; start < nc; start++) begin
      trail[0] = FIELD_W'(start);
      running_total = '0;
      for (r = 1; r < nr; r++) begin
        here = trail[r-1];
        pick = here;
        cost = energy_map[r*MAP_COLS + here];
        if (here > 0 && energy_map[r*MAP_COLS + here - 1] < cost) begin
          cost = energy_map[r*MAP_COLS + here - 1];
          pick = here - 1;
        end
        if (here + 1 < nc && energy_map[r*MAP_COLS + here + 1] < cost) begin
          cost = energy_map[r*MAP_COLS + here + 1];
          pick = here + 1;
        end
        trail[r] = FIELD_W'(pick);
        running_total += cost;
        // Pruned once it is already dearer than the best so far.
        if (running_total > lowest_total) break;
      end
      if (running_total < lowest_total) begin
        for (r = 0; r < nr; r++) kept_seam[r] = trail[r];
        lowest_total = running_total;
      end
    end
    if (nr > seam_rows_kept) seam_rows_kept = nr;
  endtask

  task automatic answer_request(input req_t r, output bit produced, output rsp_t ans);
    int unsigned slot;
    ans = '0;
    produced = 1'b0;
    unique case (r.req_type)
      REQ_WRITE: begin
        slot = int'(r.row) * MAP_COLS + int'(r.col);
        energy_map[slot] = r.energy;
        energy_known[slot] = 1'b1;
      end
      REQ_SEARCH: begin
        walk_greedy_seams();
        produced = 1'b1;
        ans.result_kind = KIND_TOTAL;
        ans.total_energy = lowest_total;
      end
      REQ_READ: begin
        produced = 1'b1;
        ans.result_kind = KIND_SEAM;
        ans.seam_col = kept_seam[r.row];
        ans.row_index = r.row;
      end
      default: ;
    endcase
  endtask

  function automatic req_t make_req(input logic [1:0] kind, input logic [FIELD_W-1:0] row,
                                    input logic [FIELD_W-1:0] col,
                                    input logic [ENERGY_W-1:0] energy);
    req_t item;
    item.req_type = kind;
    item.row = row;
    item.col = col;
    item.energy = energy;
    return item;
  endfunction

  // Low values dominate so that ties and near-ties steer the greedy choice often.
  function automatic logic [ENERGY_W-1:0] pick_energy();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return ENERGY_W'($urandom_range(0, 3));
    if (roll == 4) return '0;
    if (roll == 5) return '1;
    return ENERGY_W'($urandom);
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    plan_row_t row;
    row.kind = STEP_CFG;
    row.idx = idx;
    row.value = v;
    row.item = '0;
    row.fixed = 1'b0;
    row.want = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_req(input logic [1:0] kind, input logic [FIELD_W-1:0] r,
                                   input logic [FIELD_W-1:0] c,
                                   input logic [ENERGY_W-1:0] e);
    plan_row_t row;
    row.kind = STEP_ITEM;
    row.idx = '0;
    row.value = '0;
    row.item = make_req(kind, r, c, e);
    row.fixed = 1'b0;
    row.want = '0;
    directed_plan.push_back(row);
  endfunction

  // Pins the result of the last planned item to a value typed in by hand.
  function automatic void plan_fixed(input logic kind, input logic [TOTAL_W-1:0] total,
                                     input logic [FIELD_W-1:0] col,
                                     input logic [FIELD_W-1:0] row);
    int unsigned last;
    last = directed_plan.size() - 1;
    directed_plan[last].fixed = 1'b1;
    directed_plan[last].want.result_kind = kind;
    directed_plan[last].want.total_energy = total;
    directed_plan[last].want.seam_col = col;
    directed_plan[last].want.row_index = row;
  endfunction

  // Offers one item and holds it until the transfer; the shadow state moves at that edge.
  task automatic send_request(input req_t item, input bit fixed, input rsp_t want);
    bit   produced;
    rsp_t ans;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    answer_request(item, produced, ans);
    if (produced) pending_answers.push_back(fixed ? want : ans);
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = calm ? 0 : pick_gap();
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Stops offering and waits until every awaited result has been transferred.
  task automatic drain_answers();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROWS_USED) rows_used_reg = v;
    else if (idx == CFG_COLS_USED) cols_used_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic quiesce();
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every sample a search may touch must have been written first.
  task automatic fill_area(input int unsigned nr, input int unsigned nc);
    int unsigned r;
    int unsigned c;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        if (!energy_known[r*MAP_COLS + c]) begin
          sender_gap();
          send_request(make_req(REQ_WRITE, FIELD_W'(r), FIELD_W'(c), pick_energy()),
                       1'b0, '0);
        end
      end
    end
  endtask

  task automatic random_request(input int unsigned nr, input int unsigned nc);
    int unsigned roll;
    req_t item;
    roll = $urandom_range(0, 99);
    if (roll < 40)
      item = make_req(REQ_WRITE, FIELD_W'($urandom_range(0, nr - 1)),
                      FIELD_W'($urandom_range(0, nc - 1)), pick_energy());
    else if (roll < 50)
      item = make_req(REQ_WRITE, FIELD_W'($urandom_range(0, MAP_ROWS - 1)),
                      FIELD_W'($urandom_range(0, MAP_COLS - 1)), pick_energy());
    else if (roll < 70 || seam_rows_kept == 0)
      item = make_req(REQ_SEARCH, FIELD_W'($urandom), FIELD_W'($urandom),
                      ENERGY_W'($urandom));
    else if (roll < 95)
      item = make_req(REQ_READ, FIELD_W'($urandom_range(0, seam_rows_kept - 1)),
                      FIELD_W'($urandom), ENERGY_W'($urandom));
    else
      item = make_req(REQ_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom),
                      ENERGY_W'($urandom));
    // Now and then the sender waits for the block to empty completely.
    if ($urandom_range(0, 49) == 0) drain_answers();
    sender_gap();
    send_request(item, 1'b0, '0);
  endtask

  // One setting of the registers, with its own random traffic.
  task automatic run_phase(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val,
                           input int unsigned count, input bit squeeze);
    int unsigned nr;
    int unsigned nc;
    int unsigned k;
    quiesce();
    write_register(CFG_ROWS_USED, rows_val);
    write_register(CFG_COLS_USED, cols_val);
    if ($urandom_range(0, 1) == 0)
      write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom));
    nr = eff_dim(rows_val, MAP_ROWS);
    nc = eff_dim(cols_val, MAP_COLS);
    calm = ($urandom_range(0, 3) == 0);
    fill_area(nr, nc);
    if (squeeze) begin
      // The receiver stops for a long stretch while reads keep coming, so the
      // output side backs up and the request channel has to stall.
      send_request(make_req(REQ_SEARCH, '0, '0, '0), 1'b0, '0);
      hold_off_asked++;
      for (k = 0; k < PRESSURE_READS; k++)
        send_request(make_req(REQ_READ, FIELD_W'($urandom_range(0, seam_rows_kept - 1)),
                              FIELD_W'($urandom), ENERGY_W'($urandom)), 1'b0, '0);
    end
    for (k = 0; k < count; k++) random_request(nr, nc);
  endtask

  // Receiver: random stalls, and on request one long hold-off counted here.
  initial begin : receiver
    int unsigned gap;
    int unsigned hold_off_done;
    hold_off_done = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_asked != hold_off_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_done++;
      end else begin
        gap = calm ? 0 : pick_gap();
        if (gap == 0) begin
          rsp_ready <= 1'b1;
        end else begin
          rsp_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // Each transfer on the result channel is matched against the oldest awaited result.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result_kind %0d arrived with nothing awaited", rsp.result_kind);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, rsp.result_kind);
          mismatches++;
        end
        if (rsp.total_energy !== want.total_energy) begin
          $error("total_energy: expected %0h, got %0h", want.total_energy, rsp.total_energy);
          mismatches++;
        end
        if (rsp.seam_col !== want.seam_col) begin
          $error("seam_col: expected %0d, got %0d", want.seam_col, rsp.seam_col);
          mismatches++;
        end
        if (rsp.row_index !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, rsp.row_index);
          mismatches++;
        end
      end
    end
  end

  // The run is abandoned if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    plan_row_t   step;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_off_asked = 0;
    seam_rows_kept = 0;
    lowest_total = '1;
    running_total = '0;
    rows_used_reg = DIM_RESET;
    cols_used_reg = DIM_RESET;
    for (i = 0; i < MAP_ROWS * MAP_COLS; i++) begin
      energy_map[i] = '0;
      energy_known[i] = 1'b0;
    end
    for (i = 0; i < MAP_ROWS; i++) begin
      trail[i] = '0;
      kept_seam[i] = '0;
    end

    // Directed part. A single row makes every path total zero, so column 0 wins.
    plan_cfg(CFG_ROWS_USED, 10'd1);
    plan_cfg(CFG_COLS_USED, 10'd3);
    plan_req(REQ_WRITE, 9'd0, 9'd0, 16'h0000);
    plan_req(REQ_WRITE, 9'd0, 9'd1, 16'hFFFF);
    plan_req(REQ_WRITE, 9'd0, 9'd2, 16'h0001);
    plan_req(REQ_SEARCH, 9'd0, 9'd0, 16'h0000);
    plan_fixed(KIND_TOTAL, 32'd0, 9'd0, 9'd0);
    plan_req(REQ_READ, 9'd0, 9'd0, 16'h0000);
    plan_fixed(KIND_SEAM, 32'd0, 9'd0, 9'd0);
    // Two rows with a flat, saturated second row: the first path keeps its column.
    plan_cfg(CFG_ROWS_USED, 10'd2);
    plan_req(REQ_WRITE, 9'd1, 9'd0, 16'hFFFF);
    plan_req(REQ_WRITE, 9'd1, 9'd1, 16'hFFFF);
    plan_req(REQ_WRITE, 9'd1, 9'd2, 16'hFFFF);
    plan_req(REQ_SEARCH, 9'd0, 9'd0, 16'h0000);
    plan_fixed(KIND_TOTAL, 32'h0000_FFFF, 9'd0, 9'd0);
    plan_req(REQ_READ, 9'd1, 9'd0, 16'h0000);
    plan_fixed(KIND_SEAM, 32'd0, 9'd0, 9'd1);
    // A cheap sample at the right edge pulls a later start column across.
    plan_req(REQ_WRITE, 9'd1, 9'd2, 16'h0000);
    plan_req(REQ_SEARCH, 9'd0, 9'd0, 16'h0000);
    plan_req(REQ_READ, 9'd0, 9'd0, 16'h0000);
    plan_req(REQ_READ, 9'd1, 9'd0, 16'h0000);
    // A corner write outside the used area, and an unused request code with all ones.
    plan_req(REQ_WRITE, 9'd511, 9'd511, 16'h8000);
    plan_req(REQ_UNUSED, 9'd511, 9'd511, 16'hFFFF);
    plan_req(REQ_WRITE, 9'd1, 9'd1, 16'h0000);
    plan_req(REQ_SEARCH, 9'd0, 9'd0, 16'h0000);
    plan_req(REQ_READ, 9'd1, 9'd0, 16'h0000);
    // Zero in both registers behaves as a one-by-one map.
    plan_cfg(CFG_ROWS_USED, 10'd0);
    plan_cfg(CFG_COLS_USED, 10'd0);
    plan_cfg(CFG_SPARE_HI, 10'h3FF);
    plan_req(REQ_SEARCH, 9'd0, 9'd0, 16'h0000);
    plan_fixed(KIND_TOTAL, 32'd0, 9'd0, 9'd0);
    plan_req(REQ_READ, 9'd0, 9'd0, 16'h0000);
    plan_fixed(KIND_SEAM, 32'd0, 9'd0, 9'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_plan.size(); i++) begin
      step = directed_plan[i];
      if (step.kind == STEP_CFG) begin
        quiesce();
        write_register(step.idx, step.value);
      end else begin
        sender_gap();
        send_request(step.item, step.fixed, step.want);
      end
    end

    // Random phases: small maps first, then the extreme shapes.
    run_phase(10'd4, 10'd4, 80, 1'b1);
    run_phase(10'd2, 10'd16, 80, 1'b0);
    run_phase(10'd16, 10'd2, 80, 1'b0);
    run_phase(10'd8, 10'd8, 80, 1'b1);
    run_phase(10'd3, 10'd5, 80, 1'b0);
    run_phase(10'd10, 10'd6, 80, 1'b0);
    run_phase(10'h3FF, 10'd1, 30, 1'b0);
    run_phase(10'd512, 10'd0, 30, 1'b0);
    run_phase(10'd1, 10'd512, 30, 1'b0);
    run_phase(10'd0, 10'h3FF, 30, 1'b0);

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d results never arrived", pending_answers.size());
    end
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
